// ===== sv/skvt_pkg.sv =====
// Shared types and constants for the sorted key/data table.
// Used by skvt_ram and sorted_key_value_table_unit; depends on nothing.
package skvt_pkg;

    // One stored pair, as held in one memory word
    typedef struct packed {
        logic signed [31:0] key;
        logic signed [31:0] value;
    } entry_t;

    // Operation codes on the operation port
    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_SEARCH = 1'b1;

    // Data returned on a miss and on every insert
    localparam logic signed [31:0] NOT_FOUND_VALUE = 32'hFFFF_FFFF;

    // Sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_INSERT,
        ST_PUT
    } state_t;

endpackage

// ===== sv/skvt_ram.sv =====
// Simple dual-port entry memory: one write port, one read port, registered read data.
// Depends on skvt_pkg for entry_t.
module skvt_ram
    import skvt_pkg::*;
#(
    parameter int DEPTH = 16,
    parameter int AW    = 4
)
(
    input  logic          clk,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  entry_t        wr_data,
    input  logic          rd_en,
    input  logic [AW-1:0] rd_addr,
    output entry_t        rd_data
);

    entry_t mem [DEPTH];

    // Write one word and read one word per cycle
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// ===== sv/sorted_key_value_table_unit.sv =====
// Sorted key/data table: the controlling sequencer over one entry memory.
// Depends on skvt_pkg and skvt_ram.
//
// Holds up to CAPACITY key/data pairs in ascending key order in one memory with a
// registered read. Raise start with operation, key and value_in while busy is low;
// the item is taken at that edge. A search walks the entries from the front, one
// memory read per cycle, and stops at the first key not below the searched key.
// An insert walks from the back, moving each entry whose key is not below the new
// key up one place as it goes (the front entry only when its key is larger), and
// drops the new pair into the hole it leaves. The result appears on found, value_out
// and table_full for exactly one cycle with done high and must be taken then: there
// is no way to hold it. A new item may be started in the same cycle that done is high.
// An insert into a full table is dropped and reports table_full.
module sorted_key_value_table_unit
    import skvt_pkg::*;
#(
    parameter int CAPACITY = 16
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic               operation,
    input  logic signed [31:0] key,
    input  logic signed [31:0] value_in,
    output logic               done,
    output logic               found,
    output logic signed [31:0] value_out,
    output logic               table_full
);

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam logic [CW-1:0] FULL_COUNT = CW'(CAPACITY);

    state_t state_reg, state_next;

    logic signed [31:0] key_reg, key_next;
    logic signed [31:0] data_reg, data_next;
    logic [AW-1:0]      scan_reg, scan_next;
    logic [CW-1:0]      count_reg, count_next;

    logic               done_reg, done_next;
    logic               found_reg, found_next;
    logic signed [31:0] value_out_reg, value_out_next;
    logic               table_full_reg, table_full_next;

    logic          wr_en;
    logic [AW-1:0] wr_addr;
    entry_t        wr_data;
    logic          rd_en;
    logic [AW-1:0] rd_addr;
    entry_t        rd_data;

    logic accept;
    logic hit;
    logic equal;
    logic last;
    logic move;

    skvt_ram #(
        .DEPTH (CAPACITY),
        .AW    (AW)
    ) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign busy   = (state_reg != ST_IDLE);
    assign accept = start && !busy;

    // Compare the entry read last cycle against the held key
    assign hit   = (rd_data.key >= key_reg);
    assign equal = (rd_data.key == key_reg);
    assign last  = ((CW'(scan_reg) + CW'(1)) == count_reg);
    // Entry must move up: the front entry only when the new key sorts before it
    assign move  = (scan_reg == '0) ? (key_reg < rd_data.key) : (rd_data.key >= key_reg);

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (operation == OP_SEARCH)
                    begin
                        if (count_reg != '0)
                        begin
                            state_next = ST_SEARCH;
                        end
                    end
                    else if (count_reg != FULL_COUNT && count_reg != '0)
                    begin
                        state_next = ST_INSERT;
                    end
                end
            end
            ST_SEARCH:
            begin
                if (hit || last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_INSERT:
            begin
                if (!move)
                begin
                    state_next = ST_IDLE;
                end
                else if (scan_reg == '0)
                begin
                    state_next = ST_PUT;
                end
            end
            ST_PUT:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Memory accesses, scan pointer, count and result
    always_comb
    begin
        key_next        = key_reg;
        data_next       = data_reg;
        scan_next       = scan_reg;
        count_next      = count_reg;
        done_next       = 1'b0;
        found_next      = 1'b0;
        value_out_next  = NOT_FOUND_VALUE;
        table_full_next = 1'b0;
        rd_en           = 1'b0;
        rd_addr         = scan_reg;
        wr_en           = 1'b0;
        wr_addr         = scan_reg + AW'(1);
        wr_data.key     = key_reg;
        wr_data.value   = data_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    key_next  = key;
                    data_next = value_in;
                    if (operation == OP_SEARCH)
                    begin
                        if (count_reg == '0)
                        begin
                            done_next = 1'b1;
                        end
                        else
                        begin
                            rd_en     = 1'b1;
                            rd_addr   = '0;
                            scan_next = '0;
                        end
                    end
                    else if (count_reg == FULL_COUNT)
                    begin
                        done_next       = 1'b1;
                        table_full_next = 1'b1;
                    end
                    else if (count_reg == '0)
                    begin
                        // Empty table: place the pair at the front
                        wr_en         = 1'b1;
                        wr_addr       = '0;
                        wr_data.key   = key;
                        wr_data.value = value_in;
                        count_next    = count_reg + CW'(1);
                        done_next     = 1'b1;
                    end
                    else
                    begin
                        // Start at the last entry and work back
                        rd_en     = 1'b1;
                        rd_addr   = AW'(count_reg - CW'(1));
                        scan_next = AW'(count_reg - CW'(1));
                    end
                end
            end
            ST_SEARCH:
            begin
                if (hit)
                begin
                    done_next  = 1'b1;
                    found_next = equal;
                    if (equal)
                    begin
                        value_out_next = rd_data.value;
                    end
                end
                else if (last)
                begin
                    done_next = 1'b1;
                end
                else
                begin
                    rd_en     = 1'b1;
                    rd_addr   = scan_reg + AW'(1);
                    scan_next = scan_reg + AW'(1);
                end
            end
            ST_INSERT:
            begin
                wr_en = 1'b1;
                if (move)
                begin
                    // Shift the entry up and fetch the one below it, if there is one
                    wr_data = rd_data;
                    if (scan_reg != '0)
                    begin
                        rd_en     = 1'b1;
                        rd_addr   = scan_reg - AW'(1);
                        scan_next = scan_reg - AW'(1);
                    end
                end
                else
                begin
                    // Drop the new pair into the hole
                    count_next = count_reg + CW'(1);
                    done_next  = 1'b1;
                end
            end
            ST_PUT:
            begin
                wr_en      = 1'b1;
                wr_addr    = '0;
                count_next = count_reg + CW'(1);
                done_next  = 1'b1;
            end
            default:
            begin
                done_next = 1'b0;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            done_reg  <= done_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        key_reg        <= key_next;
        data_reg       <= data_next;
        scan_reg       <= scan_next;
        found_reg      <= found_next;
        value_out_reg  <= value_out_next;
        table_full_reg <= table_full_next;
    end

    assign done       = done_reg;
    assign found      = found_reg;
    assign value_out  = value_out_reg;
    assign table_full = table_full_reg;

    // A result is never both a hit and a dropped insert
    a_result_flags: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> !(found_reg && table_full_reg))
        else $error("found and table_full both set");

    // The strobe comes only once the sequencer is back at rest
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> (state_reg == ST_IDLE))
        else $error("result strobe while sequencer active");

    // The count moves only by one, and only as an insert completes
    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg != $past(count_reg)) |->
            (done_reg && (count_reg == $past(count_reg) + CW'(1))))
        else $error("entry count changed unexpectedly");

    // Never exceed the capacity
    a_count_cap: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= FULL_COUNT)
        else $error("entry count above capacity");

    // The shifting walk never reads and writes the same entry in one cycle
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        (wr_en && rd_en) |-> (wr_addr != rd_addr))
        else $error("read and write to the same entry");

endmodule
